// ===== hw/rtl/trsr_pkg.sv =====
// trsr_pkg: shared types and constants for the triangle row span rasterizer
// coordinate format, transfer payload structs, state encoding, register indexes
// no dependencies
package trsr_pkg;

  localparam int COORD_INT_BITS  = 12;
  localparam int COORD_FRAC_BITS = 4;
  localparam int COORD_W         = COORD_INT_BITS + COORD_FRAC_BITS;
  localparam int DIFF_W          = COORD_W + 1;
  localparam int PROD_W          = 2 * DIFF_W;
  localparam int ACC_W           = PROD_W + 1;
  localparam int COLOUR_W        = 8;

  // one pair of products per edge evaluation: area, three tie-point sides, three start values
  localparam int NUM_EVALS  = 7;
  localparam int NUM_TERMS  = 2 * NUM_EVALS;
  localparam int CNT_W      = $clog2(NUM_TERMS + 1);

  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIE_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TIE_Y = CFG_IDX_W'(1);

  typedef logic signed [COORD_W-1:0]        coord_t;
  typedef logic signed [COORD_INT_BITS-1:0] pix_t;
  typedef logic signed [COORD_INT_BITS:0]   pix_wide_t;
  typedef logic signed [DIFF_W-1:0]         diff_t;
  typedef logic signed [PROD_W-1:0]         prod_t;
  typedef logic signed [ACC_W-1:0]          acc_t;

  // -1.0 in the coordinate format
  localparam coord_t TIE_RESET = coord_t'(-(2 ** COORD_FRAC_BITS));
  // largest column that span_last can carry
  localparam pix_wide_t X_HI = pix_wide_t'(2 ** (COORD_INT_BITS - 1) - 1);
  localparam diff_t CEIL_BIAS = diff_t'(2 ** COORD_FRAC_BITS - 1);

  typedef struct packed {
    logic signed [COORD_W-1:0]        vert0_x;
    logic signed [COORD_W-1:0]        vert0_y;
    logic signed [COORD_W-1:0]        vert1_x;
    logic signed [COORD_W-1:0]        vert1_y;
    logic signed [COORD_W-1:0]        vert2_x;
    logic signed [COORD_W-1:0]        vert2_y;
    logic signed [COORD_INT_BITS-1:0] scan_row;
    logic [COLOUR_W-1:0]              red_in;
    logic [COLOUR_W-1:0]              green_in;
    logic [COLOUR_W-1:0]              blue_in;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_INT_BITS-1:0] row_out;
    logic signed [COORD_INT_BITS-1:0] span_first;
    logic signed [COORD_INT_BITS-1:0] span_last;
    logic                             span_empty;
    logic [COLOUR_W-1:0]              red_out;
    logic [COLOUR_W-1:0]              green_out;
    logic [COLOUR_W-1:0]              blue_out;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

endpackage

// ===== hw/rtl/triangle_row_span_rasterizer.sv =====
// triangle_row_span_rasterizer: one pixel row of a triangle to a covered span
// edge functions set up on one shared multiplier, then walked column by column
// depends on trsr_pkg
// sequence: an item is taken only in idle; setup evaluates the edge functions on the shared
//   multiplier, the walk visits each column of the clipped floor/ceil bounding box (no walk for
//   a degenerate triangle or a row outside the box), then the result is handed over once the
//   previous result has been taken on out_ready_i, and the block returns to idle; it does not
//   accept a new item until the last one has reached the output register
// reset: idle, no result held, tie point at (-1.0, -1.0)
module triangle_row_span_rasterizer
  import trsr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_W-1:0]   cfg_data_i
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q, found_q;
  coord_t           tie_x_q, tie_y_q;

  in_item_t  item_q;
  out_item_t out_q;
  pix_t      xmin_q, xmax_q, x_q, first_q, last_q;
  logic      box_ok_q;
  prod_t     prod_q;
  acc_t      acc_q, area_q;
  acc_t      tie_w_q [3];
  acc_t      e_q [3];

  logic in_xfer;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // bounding box of the incoming triangle
  pix_t      xmin_d, xmax_d;
  logic      box_ok_d;
  always_comb begin
    coord_t    mnx, mxx, mny, mxy;
    diff_t     cx, cy;
    pix_wide_t xceil, yceil, row_w;
    pix_t      ymin;
    mnx = in_data_i.vert0_x;
    mxx = in_data_i.vert0_x;
    mny = in_data_i.vert0_y;
    mxy = in_data_i.vert0_y;
    if (in_data_i.vert1_x < mnx) mnx = in_data_i.vert1_x;
    if (in_data_i.vert2_x < mnx) mnx = in_data_i.vert2_x;
    if (in_data_i.vert1_x > mxx) mxx = in_data_i.vert1_x;
    if (in_data_i.vert2_x > mxx) mxx = in_data_i.vert2_x;
    if (in_data_i.vert1_y < mny) mny = in_data_i.vert1_y;
    if (in_data_i.vert2_y < mny) mny = in_data_i.vert2_y;
    if (in_data_i.vert1_y > mxy) mxy = in_data_i.vert1_y;
    if (in_data_i.vert2_y > mxy) mxy = in_data_i.vert2_y;
    xmin_d = $signed(mnx[COORD_W-1:COORD_FRAC_BITS]);
    ymin   = $signed(mny[COORD_W-1:COORD_FRAC_BITS]);
    cx     = diff_t'(mxx) + CEIL_BIAS;
    cy     = diff_t'(mxy) + CEIL_BIAS;
    xceil  = $signed(cx[DIFF_W-1:COORD_FRAC_BITS]);
    yceil  = $signed(cy[DIFF_W-1:COORD_FRAC_BITS]);
    if (xceil > X_HI) xmax_d = pix_t'(X_HI);
    else              xmax_d = xceil[COORD_INT_BITS-1:0];
    row_w    = pix_wide_t'(in_data_i.scan_row);
    box_ok_d = !(in_data_i.scan_row < ymin) && !(row_w > yceil);
  end

  coord_t vx [3];
  coord_t vy [3];
  assign vx[0] = item_q.vert0_x;
  assign vy[0] = item_q.vert0_y;
  assign vx[1] = item_q.vert1_x;
  assign vy[1] = item_q.vert1_y;
  assign vx[2] = item_q.vert2_x;
  assign vy[2] = item_q.vert2_y;

  // per-column increment of each edge function, edge k runs from vertex k+1 to k+2
  acc_t step [3];
  assign step[0] = acc_t'(diff_t'(vy[1]) - diff_t'(vy[2])) <<< COORD_FRAC_BITS;
  assign step[1] = acc_t'(diff_t'(vy[2]) - diff_t'(vy[0])) <<< COORD_FRAC_BITS;
  assign step[2] = acc_t'(diff_t'(vy[0]) - diff_t'(vy[1])) <<< COORD_FRAC_BITS;

  // shared multiplier operands: term t is half t[0] of evaluation t[3:1]
  // E = (a.y - b.y) * (p.x - a.x) + (b.x - a.x) * (p.y - a.y)
  prod_t prod_d;
  always_comb begin
    logic [2:0] ev;
    logic [1:0] ka, kb;
    coord_t     px, py;
    diff_t      opa, opb;
    ev = cnt_q[3:1];
    case (ev)
      3'd0: begin ka = 2'd1; kb = 2'd2; px = vx[0]; py = vy[0]; end
      3'd1: begin ka = 2'd1; kb = 2'd2; px = tie_x_q; py = tie_y_q; end
      3'd2: begin ka = 2'd2; kb = 2'd0; px = tie_x_q; py = tie_y_q; end
      3'd3: begin ka = 2'd0; kb = 2'd1; px = tie_x_q; py = tie_y_q; end
      3'd4: begin
        ka = 2'd1; kb = 2'd2;
        px = coord_t'(xmin_q) <<< COORD_FRAC_BITS;
        py = coord_t'(item_q.scan_row) <<< COORD_FRAC_BITS;
      end
      3'd5: begin
        ka = 2'd2; kb = 2'd0;
        px = coord_t'(xmin_q) <<< COORD_FRAC_BITS;
        py = coord_t'(item_q.scan_row) <<< COORD_FRAC_BITS;
      end
      default: begin
        ka = 2'd0; kb = 2'd1;
        px = coord_t'(xmin_q) <<< COORD_FRAC_BITS;
        py = coord_t'(item_q.scan_row) <<< COORD_FRAC_BITS;
      end
    endcase
    if (cnt_q[0]) begin
      opa = diff_t'(vx[kb]) - diff_t'(vx[ka]);
      opb = diff_t'(py) - diff_t'(vy[ka]);
    end else begin
      opa = diff_t'(vy[ka]) - diff_t'(vy[kb]);
      opb = diff_t'(px) - diff_t'(vx[ka]);
    end
    prod_d = opa * opb;
  end

  // accumulate the product of the previous term
  logic [CNT_W-1:0] ct;
  logic [2:0]       dest;
  acc_t             sum;
  assign ct   = cnt_q - CNT_W'(1);
  assign dest = ct[3:1];
  assign sum  = acc_q + acc_t'(prod_q);

  // coverage at the current column, orientation folded into the sign tests
  logic covered;
  always_comb begin
    logic apos, n, z, tn, tz, nonneg, pos, tpos;
    apos    = !area_q[ACC_W-1];
    covered = 1'b1;
    for (int k = 0; k < 3; k++) begin
      n      = e_q[k][ACC_W-1];
      z      = (e_q[k] == '0);
      tn     = tie_w_q[k][ACC_W-1];
      tz     = (tie_w_q[k] == '0);
      nonneg = apos ? !n : (n || z);
      pos    = apos ? (!n && !z) : n;
      tpos   = apos ? (!tn && !tz) : tn;
      covered = covered && nonneg && (pos || tpos);
    end
  end

  logic setup_last, walk_last;
  assign setup_last = (cnt_q == CNT_W'(NUM_TERMS));
  assign walk_last  = (x_q == xmax_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_xfer) state_d = ST_SETUP;
      ST_SETUP: begin
        if (setup_last) begin
          if (box_ok_q && (area_q != '0)) state_d = ST_WALK;
          else                           state_d = ST_DONE;
        end
      end
      ST_WALK:  if (walk_last) state_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      tie_x_q     <= TIE_RESET;
      tie_y_q     <= TIE_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TIE_X: tie_x_q <= cfg_data_i;
          CFG_TIE_Y: tie_y_q <= cfg_data_i;
          default:   ;
        endcase
      end
      if (in_xfer) begin
        cnt_q   <= '0;
        found_q <= 1'b0;
      end else if (state_q == ST_SETUP) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (state_q == ST_WALK && covered) found_q <= 1'b1;
      if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_ready_i)                                     out_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q   <= in_data_i;
      xmin_q   <= xmin_d;
      xmax_q   <= xmax_d;
      box_ok_q <= box_ok_d;
    end
    if (state_q == ST_SETUP) begin
      prod_q <= prod_d;
      if (cnt_q != '0) begin
        if (!ct[0]) begin
          acc_q <= acc_t'(prod_q);
        end else if (dest == 3'd0) begin
          area_q <= sum;
        end else if (dest <= 3'd3) begin
          tie_w_q[2'(dest - 3'd1)] <= sum;
        end else begin
          e_q[2'(dest - 3'd4)] <= sum;
        end
      end
      if (setup_last) x_q <= xmin_q;
    end
    if (state_q == ST_WALK) begin
      if (covered) begin
        if (!found_q) first_q <= x_q;
        last_q <= x_q;
      end
      x_q <= x_q + pix_t'(1);
      for (int k = 0; k < 3; k++) e_q[k] <= e_q[k] + step[k];
    end
    if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
      out_q.row_out    <= item_q.scan_row;
      out_q.span_first <= found_q ? first_q : '0;
      out_q.span_last  <= found_q ? last_q : '0;
      out_q.span_empty <= !found_q;
      out_q.red_out    <= item_q.red_in;
      out_q.green_out  <= item_q.green_in;
      out_q.blue_out   <= item_q.blue_in;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_SETUP && cnt_q == '0))
    else $error("input transfer did not start setup");

  a_walk_needs_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (area_q != '0 && box_ok_q))
    else $error("walk on a degenerate triangle or a row outside the box");

  a_walk_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (x_q >= xmin_q && x_q <= xmax_q))
    else $error("column left the bounding box");

  a_span_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.span_empty) |-> (out_q.span_first <= out_q.span_last))
    else $error("span first beyond span last");
`endif

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for triangle_row_span_rasterizer, directed rows then random
// triangles under several tie points, each span checked against an edge-function predictor or,
// for directed rows known to be empty, against an empty span; depends on trsr_pkg and triangle_row_span_rasterizer
module tb_top;
  import trsr_pkg::*;

  localparam int  RANDOM_PER_PHASE = 84;
  localparam int  NUM_PHASES       = 6;
  localparam int  LONG_HOLD        = 400;
  localparam int  SETTLE_CYCLES    = 200;
  localparam int  MAX_SHOWN        = 10;
  localparam longint RUN_LIMIT     = 50000000;

  typedef enum int {RX_ALWAYS, RX_PATTERN, RX_RANDOM} rx_mode_e;

  typedef struct {
    in_item_t item;
    bit       known_empty;
  } probe_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_item_t            out_data_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_TIE_X;
  logic [COORD_W-1:0]   cfg_data_i = '0;

  // copy of the tie point as the block holds it
  coord_t    tie_x = TIE_RESET;
  coord_t    tie_y = TIE_RESET;
  out_item_t exp_spans[$];
  int        mismatches = 0;
  int        burst_left = 0;
  bit        tx_steady = 1'b0;
  rx_mode_e  rx_mode = RX_RANDOM;
  logic [15:0] rx_pat = 16'hb3c5;
  int        rx_hold_req = 0;
  int        rx_hold_left = 0;

  triangle_row_span_rasterizer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // edge function of the directed edge a->b at point p
  function automatic longint edge_val(input longint ax, input longint ay, input longint bx,
                                      input longint by, input longint px, input longint py);
    return (ay - by) * px + (bx - ax) * py + ax * by - bx * ay;
  endfunction

  function automatic out_item_t predict_span(input in_item_t it);
    longint    vx[3], vy[3], side[3];
    longint    area, sgn, xlo, xhi, ylo, yhi, row, px, py, ev, first, last, col_max;
    bit        hit, covered;
    out_item_t r;
    vx[0] = it.vert0_x;
    vy[0] = it.vert0_y;
    vx[1] = it.vert1_x;
    vy[1] = it.vert1_y;
    vx[2] = it.vert2_x;
    vy[2] = it.vert2_y;
    row = it.scan_row;
    area = edge_val(vx[1], vy[1], vx[2], vy[2], vx[0], vy[0]);
    sgn = (area > 0) ? 1 : -1;
    xlo = vx[0];
    xhi = vx[0];
    ylo = vy[0];
    yhi = vy[0];
    for (int i = 1; i < 3; i++) begin
      if (vx[i] < xlo) xlo = vx[i];
      if (vx[i] > xhi) xhi = vx[i];
      if (vy[i] < ylo) ylo = vy[i];
      if (vy[i] > yhi) yhi = vy[i];
    end
    // floor and ceiling to whole pixels
    xlo = xlo >>> COORD_FRAC_BITS;
    ylo = ylo >>> COORD_FRAC_BITS;
    xhi = -((-xhi) >>> COORD_FRAC_BITS);
    yhi = -((-yhi) >>> COORD_FRAC_BITS);
    col_max = (longint'(1) <<< (COORD_INT_BITS - 1)) - 1;
    if (xhi > col_max) xhi = col_max;
    for (int i = 0; i < 3; i++) begin
      side[i] = sgn * edge_val(vx[(i + 1) % 3], vy[(i + 1) % 3], vx[(i + 2) % 3],
                               vy[(i + 2) % 3], longint'(tie_x), longint'(tie_y));
    end
    hit = 1'b0;
    first = 0;
    last = 0;
    if (area != 0 && row >= ylo && row <= yhi) begin
      py = row <<< COORD_FRAC_BITS;
      for (longint x = xlo; x <= xhi; x++) begin
        px = x <<< COORD_FRAC_BITS;
        covered = 1'b1;
        for (int i = 0; i < 3; i++) begin
          ev = sgn * edge_val(vx[(i + 1) % 3], vy[(i + 1) % 3], vx[(i + 2) % 3],
                              vy[(i + 2) % 3], px, py);
          // a pixel on an edge counts only if the tie point is inside that edge
          if (ev < 0 || (ev == 0 && side[i] <= 0)) covered = 1'b0;
        end
        if (covered) begin
          if (!hit) first = x;
          last = x;
          hit = 1'b1;
        end
      end
    end
    r.row_out    = it.scan_row;
    r.span_first = hit ? pix_t'(first) : '0;
    r.span_last  = hit ? pix_t'(last) : '0;
    r.span_empty = ~hit;
    r.red_out    = it.red_in;
    r.green_out  = it.green_in;
    r.blue_out   = it.blue_in;
    return r;
  endfunction

  function automatic in_item_t tri_item(input longint x0, input longint y0, input longint x1,
                                        input longint y1, input longint x2, input longint y2,
                                        input longint row, input int r, input int g,
                                        input int b);
    in_item_t it;
    it.vert0_x  = coord_t'(x0);
    it.vert0_y  = coord_t'(y0);
    it.vert1_x  = coord_t'(x1);
    it.vert1_y  = coord_t'(y1);
    it.vert2_x  = coord_t'(x2);
    it.vert2_y  = coord_t'(y2);
    it.scan_row = pix_t'(row);
    it.red_in   = COLOUR_W'(r);
    it.green_in = COLOUR_W'(g);
    it.blue_in  = COLOUR_W'(b);
    return it;
  endfunction

  function automatic in_item_t random_triangle();
    in_item_t it;
    longint   vx[3], vy[3];
    longint   ax, ay, reach, k, row;
    int       kind;
    bit       snap;
    kind = $urandom_range(0, 99);
    snap = $urandom_range(0, 1);
    if (kind < 6) begin
      // anywhere in the coordinate range, mostly wide boxes
      {it.vert0_x, it.vert0_y, it.vert1_x, it.vert1_y, it.vert2_x, it.vert2_y} =
        {$urandom, $urandom, $urandom};
      it.scan_row = pix_t'($urandom);
    end else begin
      reach = ($urandom_range(0, 3) == 0) ? 1024 : 256;
      if (kind < 14) begin
        ax = tie_x;
        ay = tie_y;
      end else begin
        ax = longint'($urandom_range(0, 60000)) - 30000;
        ay = longint'($urandom_range(0, 60000)) - 30000;
      end
      for (int i = 0; i < 3; i++) begin
        vx[i] = ax + longint'($urandom_range(0, int'(2 * reach))) - reach;
        vy[i] = ay + longint'($urandom_range(0, int'(2 * reach))) - reach;
        if (snap) begin
          vx[i] = (vx[i] >>> COORD_FRAC_BITS) <<< COORD_FRAC_BITS;
          vy[i] = (vy[i] >>> COORD_FRAC_BITS) <<< COORD_FRAC_BITS;
        end
      end
      if (kind < 14) begin
        // edge v0->v1 runs through the tie point
        vx[0] = 2 * ax - vx[1];
        vy[0] = 2 * ay - vy[1];
      end else if (kind < 20) begin
        // collinear vertices
        vx[2] = 2 * vx[1] - vx[0];
        vy[2] = 2 * vy[1] - vy[0];
      end
      it.vert0_x = coord_t'(clamp(vx[0], -32768, 32767));
      it.vert0_y = coord_t'(clamp(vy[0], -32768, 32767));
      it.vert1_x = coord_t'(clamp(vx[1], -32768, 32767));
      it.vert1_y = coord_t'(clamp(vy[1], -32768, 32767));
      it.vert2_x = coord_t'(clamp(vx[2], -32768, 32767));
      it.vert2_y = coord_t'(clamp(vy[2], -32768, 32767));
      k = reach / 16 + 3;
      row = (ay >>> COORD_FRAC_BITS) + longint'($urandom_range(0, int'(2 * k))) - k;
      it.scan_row = pix_t'(clamp(row, -2048, 2047));
    end
    it.red_in   = COLOUR_W'($urandom);
    it.green_in = COLOUR_W'($urandom);
    it.blue_in  = COLOUR_W'($urandom);
    return it;
  endfunction

  function automatic string span_str(input out_item_t s);
    return $sformatf("row %0d first %0d last %0d empty %0b rgb %02x %02x %02x", s.row_out,
                     s.span_first, s.span_last, s.span_empty, s.red_out, s.green_out,
                     s.blue_out);
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input in_item_t it, input bit known_empty);
    out_item_t want;
    if (burst_left == 0) begin
      if (!tx_steady) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 40)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    if (known_empty) begin
      want.row_out    = it.scan_row;
      want.span_first = '0;
      want.span_last  = '0;
      want.span_empty = 1'b1;
      want.red_out    = it.red_in;
      want.green_out  = it.green_in;
      want.blue_out   = it.blue_in;
    end else begin
      want = predict_span(it);
    end
    exp_spans.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (exp_spans.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_tie(input coord_t x, input coord_t y);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_TIE_X;
    cfg_data_i <= x;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_TIE_Y;
    cfg_data_i <= y;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    tie_x = x;
    tie_y = y;
  endtask

  always @(negedge clk_i) begin : receiver
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      out_ready_i <= 1'b0;
      rx_hold_left--;
    end else begin
      case (rx_mode)
        RX_ALWAYS: begin
          out_ready_i <= 1'b1;
        end
        RX_PATTERN: begin
          out_ready_i <= rx_pat[0];
          rx_pat = {rx_pat[0], rx_pat[15:1]};
        end
        default: begin
          out_ready_i <= ($urandom_range(0, 2) != 0);
        end
      endcase
    end
  end

  always @(posedge clk_i) begin : span_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (exp_spans.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("unexpected span transfer: %s", span_str(out_data_o));
        end
      end else begin
        want = exp_spans.pop_front();
        if (out_data_o.row_out !== want.row_out || out_data_o.span_first !== want.span_first ||
            out_data_o.span_last !== want.span_last ||
            out_data_o.span_empty !== want.span_empty ||
            out_data_o.red_out !== want.red_out || out_data_o.green_out !== want.green_out ||
            out_data_o.blue_out !== want.blue_out) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("span mismatch: expected %s", span_str(want));
            $display("               actual   %s", span_str(out_data_o));
          end
        end
      end
    end
  end

  initial begin : stimulus
    probe_t probes[$];
    coord_t tie_xs[NUM_PHASES];
    coord_t tie_ys[NUM_PHASES];
    tie_xs = '{16'sd0, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd0, -16'sd16};
    tie_ys = '{16'sd0, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd0, -16'sd16};
    // coincident, collinear and flat-at-extremes triangles
    probes.push_back('{tri_item(0, 0, 0, 0, 0, 0, 0, 'hff, 'h00, 'hff), 1'b1});
    probes.push_back('{tri_item(0, 0, 160, 160, 320, 320, 5, 'h12, 'h34, 'h56), 1'b1});
    probes.push_back('{tri_item(-32768, 0, 0, 0, 32767, 0, 0, 'h00, 'hff, 'h00), 1'b1});
    // rows outside the box
    probes.push_back('{tri_item(0, 0, 160, 0, 0, 160, -5, 'ha5, 'h5a, 'h01), 1'b1});
    probes.push_back('{tri_item(0, 0, 160, 0, 0, 160, 20, 'h5a, 'ha5, 'h80), 1'b1});
    probes.push_back('{tri_item(0, 0, 160, 0, 0, 160, -2048, 'hff, 'hff, 'hff), 1'b1});
    probes.push_back('{tri_item(0, 0, 160, 0, 0, 160, 2047, 'h00, 'h00, 'h00), 1'b1});
    // plain triangle, both windings, bottom edge and apex
    probes.push_back('{tri_item(0, 0, 160, 0, 0, 160, 0, 'h11, 'h22, 'h33), 1'b0});
    probes.push_back('{tri_item(0, 0, 160, 0, 0, 160, 5, 'h44, 'h55, 'h66), 1'b0});
    probes.push_back('{tri_item(0, 0, 0, 160, 160, 0, 5, 'h77, 'h88, 'h99), 1'b0});
    probes.push_back('{tri_item(0, 0, 0, 160, 160, 0, 10, 'haa, 'hbb, 'hcc), 1'b0});
    // edge through the reset tie point
    probes.push_back('{tri_item(-16, -16, 160, 160, 160, -16, 3, 'hdd, 'hee, 'hff), 1'b0});
    probes.push_back('{tri_item(-16, -16, 160, 160, 160, -16, 8, 'h01, 'h02, 'h04), 1'b0});
    // sub-pixel and fractional negative vertices
    probes.push_back('{tri_item(1, 1, 14, 1, 1, 14, 0, 'h08, 'h10, 'h20), 1'b0});
    probes.push_back('{tri_item(-40, -23, 57, -9, 3, 71, 0, 'h40, 'h80, 'hfe), 1'b0});
    probes.push_back('{tri_item(-40, -23, 57, -9, 3, 71, -1, 'hfd, 'hfb, 'hf7), 1'b0});
    // full-range triangles, right side clipped
    probes.push_back('{tri_item(-32768, -32768, 32767, -32768, -32768, 32767, -2048,
                                'hef, 'hdf, 'hbf), 1'b0});
    probes.push_back('{tri_item(-32768, -32768, 32767, -32768, -32768, 32767, 2047,
                                'h7f, 'h3c, 'hc3), 1'b0});
    probes.push_back('{tri_item(32767, 32767, -32768, 32767, 32767, -32768, 0,
                                'h0f, 'hf0, 'h69), 1'b0});
    probes.push_back('{tri_item(32000, 0, 32767, 0, 32767, 320, 10, 'h96, 'h5a, 'hc6), 1'b0});
    // thin sliver and negative quadrant
    probes.push_back('{tri_item(0, 0, 1600, 16, 0, 1, 0, 'h31, 'h62, 'hc4), 1'b0});
    probes.push_back('{tri_item(-320, -320, -160, -320, -320, -160, -15, 'h9c, 'h39, 'h73),
                       1'b0});

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed rows run on the tie point left by reset
    foreach (probes[i]) send_item(probes[i].item, probes[i].known_empty);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      if (ph == 4) begin
        tie_xs[ph] = coord_t'($urandom);
        tie_ys[ph] = coord_t'($urandom);
      end
      write_tie(tie_xs[ph], tie_ys[ph]);
      rx_mode   = rx_mode_e'(ph % 3);
      rx_pat    = 16'($urandom) | 16'h0001;
      tx_steady = ($urandom_range(0, 2) == 0);
      // receiver holds off while the sender keeps offering, so the input backs up
      if (ph == 1) rx_hold_req = LONG_HOLD;
      repeat (RANDOM_PER_PHASE) send_item(random_triangle(), 1'b0);
    end
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && exp_spans.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin : watchdog
    #RUN_LIMIT;
    $display("tb_top failed");
    $finish;
  end

endmodule
